// File: rtl/wit_pkg.sv
// ----------------------------------------------------------------------------
// wit_pkg
// shared constants and coefficient table of the winograd input tile transform
// ----------------------------------------------------------------------------
package wit_pkg;

    // tile edge, rows per tile and values per row
    localparam int TILE = 6;
    // bits of the output row index
    localparam int ROW_IDX_WIDTH = 3;
    // growth of a value through the row transform and through both transforms
    localparam int ROW_GROWTH = 4;
    localparam int TILE_GROWTH = 7;

    typedef logic signed [3:0] t_coef;

    // bt matrix of f(4x4,3x3), row c gives the weights of x0..x5 for y_c
    localparam t_coef BT [TILE][TILE] = '{
        '{ 4'sd4,  4'sd0, -4'sd5,  4'sd0,  4'sd1,  4'sd0},
        '{ 4'sd0, -4'sd4, -4'sd4,  4'sd1,  4'sd1,  4'sd0},
        '{ 4'sd0,  4'sd4, -4'sd4, -4'sd1,  4'sd1,  4'sd0},
        '{ 4'sd0, -4'sd2, -4'sd1,  4'sd2,  4'sd1,  4'sd0},
        '{ 4'sd0,  4'sd2, -4'sd1, -4'sd2,  4'sd1,  4'sd0},
        '{ 4'sd0,  4'sd4,  4'sd0, -4'sd5,  4'sd0,  4'sd1}
    };

endpackage

// File: rtl/wit_in_if.sv
// ----------------------------------------------------------------------------
// wit_in_if
// request channel carrying one tile row and its column mask
// ----------------------------------------------------------------------------
interface wit_in_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                                valid;
    logic                                ready;
    logic signed [VALUE_WIDTH-1:0]       in_value_0;
    logic signed [VALUE_WIDTH-1:0]       in_value_1;
    logic signed [VALUE_WIDTH-1:0]       in_value_2;
    logic signed [VALUE_WIDTH-1:0]       in_value_3;
    logic signed [VALUE_WIDTH-1:0]       in_value_4;
    logic signed [VALUE_WIDTH-1:0]       in_value_5;
    logic        [wit_pkg::TILE-1:0]     column_valid_mask;

    modport source (
        output valid, in_value_0, in_value_1, in_value_2, in_value_3,
               in_value_4, in_value_5, column_valid_mask,
        input  ready
    );
    modport sink (
        input  valid, in_value_0, in_value_1, in_value_2, in_value_3,
               in_value_4, in_value_5, column_valid_mask,
        output ready
    );
endinterface

// File: rtl/wit_out_if.sv
// ----------------------------------------------------------------------------
// wit_out_if
// result channel carrying one transformed tile row
// ----------------------------------------------------------------------------
interface wit_out_if #(
    parameter int VALUE_WIDTH = 16
);
    localparam int OUT_WIDTH = VALUE_WIDTH + wit_pkg::TILE_GROWTH;

    logic                                   valid;
    logic                                   ready;
    logic signed [OUT_WIDTH-1:0]            out_value_0;
    logic signed [OUT_WIDTH-1:0]            out_value_1;
    logic signed [OUT_WIDTH-1:0]            out_value_2;
    logic signed [OUT_WIDTH-1:0]            out_value_3;
    logic signed [OUT_WIDTH-1:0]            out_value_4;
    logic signed [OUT_WIDTH-1:0]            out_value_5;
    logic        [wit_pkg::ROW_IDX_WIDTH-1:0] out_row;
    logic                                   tile_done;

    modport source (
        output valid, out_value_0, out_value_1, out_value_2, out_value_3,
               out_value_4, out_value_5, out_row, tile_done,
        input  ready
    );
    modport sink (
        input  valid, out_value_0, out_value_1, out_value_2, out_value_3,
               out_value_4, out_value_5, out_row, tile_done,
        output ready
    );
endinterface

// File: rtl/wit_ram.sv
// ----------------------------------------------------------------------------
// wit_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/winograd_f4x3_input_tile_transform.sv
// ----------------------------------------------------------------------------
// winograd_f4x3_input_tile_transform
// winograd f(4x4,3x3) input transform u = bt * d * b of one 6x6 tile
// ----------------------------------------------------------------------------
// flow: after the sixth row request is taken, the six stored rows are read and
//   folded into the result buffer, then one row per cycle while the sink is ready
// throughput: up to one row request per cycle, but the sixth row of a tile waits
//   while the column pass is busy, as the store reads and result rows share one buffer
// reset: synchronous active-low, clears row count, bank, phase; store is not cleared
module winograd_f4x3_input_tile_transform #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wit_in_if.sink    i_in,
    wit_out_if.source o_out
);

    localparam int TILE       = wit_pkg::TILE;
    localparam int SW         = VALUE_WIDTH + wit_pkg::ROW_GROWTH;   // stored value width
    localparam int OW         = VALUE_WIDTH + wit_pkg::TILE_GROWTH;  // result width
    localparam int RAM_DEPTH  = 2 * TILE;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int RW         = wit_pkg::ROW_IDX_WIDTH;

    // phase of the column pass
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [RW-1:0] LAST_ROW = RW'(TILE - 1);

    // weight one stored value by a small integer coefficient, exact in ow bits
    function automatic logic signed [OW-1:0] scale(
        input logic signed [SW-1:0] v,
        input wit_pkg::t_coef       c
    );
        logic signed [OW-1:0] ve;
        logic signed [OW-1:0] res;
        ve = OW'(v);
        case (c)
            4'sd1:   res = ve;
            -4'sd1:  res = -ve;
            4'sd2:   res = ve <<< 1;
            -4'sd2:  res = -(ve <<< 1);
            4'sd4:   res = ve <<< 2;
            -4'sd4:  res = -(ve <<< 2);
            4'sd5:   res = (ve <<< 2) + ve;
            -4'sd5:  res = -((ve <<< 2) + ve);
            default: res = '0;
        endcase
        return res;
    endfunction

    // row bookkeeping
    logic [RW-1:0]     r_rows, n_rows;
    logic              r_bank, n_bank;

    // column pass control
    logic [1:0]        r_state, n_state;
    logic [RW-1:0]     r_rd_cnt, n_rd_cnt;     // counts to tile so it can mark the end
    logic              r_rd_bank, n_rd_bank;
    logic              r_acc_vld;
    logic [RW-1:0]     r_acc_j;
    logic [RW-1:0]     r_out_row, n_out_row;

    // accumulated result tile, payload only
    logic signed [OW-1:0] r_acc [TILE][TILE];

    logic                 in_acc;
    logic                 out_acc;
    logic                 rd_en;
    logic signed [VALUE_WIDTH-1:0] x_raw [TILE];
    logic signed [SW-1:0] x_row [TILE];
    logic [TILE*SW-1:0]   wr_data;
    logic [TILE*SW-1:0]   rd_data;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;

    // sixth row of a tile waits until the result buffer is free
    assign i_in.ready = !((r_rows == LAST_ROW) && (r_state != ST_IDLE));
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    assign x_raw[0] = i_in.in_value_0;
    assign x_raw[1] = i_in.in_value_1;
    assign x_raw[2] = i_in.in_value_2;
    assign x_raw[3] = i_in.in_value_3;
    assign x_raw[4] = i_in.in_value_4;
    assign x_raw[5] = i_in.in_value_5;

    // masked row followed by the 1d transform
    always_comb begin
        logic signed [OW-1:0] sum;
        for (int m = 0; m < TILE; m++) begin
            x_row[m] = i_in.column_valid_mask[m] ? SW'(x_raw[m]) : '0;
        end
        for (int c = 0; c < TILE; c++) begin
            sum = '0;
            for (int m = 0; m < TILE; m++) begin
                sum = sum + scale(x_row[m], wit_pkg::BT[c][m]);
            end
            wr_data[c*SW +: SW] = sum[SW-1:0];
        end
    end

    // bank b holds rows at addresses b*tile .. b*tile+5
    assign wr_addr = r_bank    ? ADDR_W'(TILE + 32'(r_rows))            : ADDR_W'(r_rows);
    assign rd_addr = r_rd_bank ? ADDR_W'(TILE + 32'(r_rd_cnt))          : ADDR_W'(r_rd_cnt);
    assign rd_en   = (r_state == ST_READ) && (r_rd_cnt != RW'(TILE));

    wit_ram #(
        .WIDTH (TILE * SW),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // next state of rows, bank and column pass
    always_comb begin
        n_rows    = r_rows;
        n_bank    = r_bank;
        n_state   = r_state;
        n_rd_cnt  = r_rd_cnt;
        n_rd_bank = r_rd_bank;
        n_out_row = r_out_row;

        if (in_acc) begin
            if (r_rows == LAST_ROW) begin
                n_rows = '0;
                n_bank = !r_bank;
            end else begin
                n_rows = r_rows + 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (r_rows == LAST_ROW)) begin
                    n_state   = ST_READ;
                    n_rd_cnt  = '0;
                    n_rd_bank = r_bank;
                end
            end
            ST_READ: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                // last stored row folded in at this edge
                if (r_acc_vld && (r_acc_j == LAST_ROW)) begin
                    n_state   = ST_EMIT;
                    n_out_row = '0;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (r_out_row == LAST_ROW) begin
                        n_state   = ST_IDLE;
                        n_out_row = '0;
                    end else begin
                        n_out_row = r_out_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= '0;
            r_bank    <= 1'b0;
            r_state   <= ST_IDLE;
            r_rd_cnt  <= '0;
            r_rd_bank <= 1'b0;
            r_acc_vld <= 1'b0;
            r_acc_j   <= '0;
            r_out_row <= '0;
        end else begin
            r_rows    <= n_rows;
            r_bank    <= n_bank;
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_rd_bank <= n_rd_bank;
            r_acc_vld <= rd_en;
            r_acc_j   <= r_rd_cnt;
            r_out_row <= n_out_row;
        end
    end

    // column transform: each stored row j adds its weighted share to every result row
    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            for (int k = 0; k < TILE; k++) begin
                for (int i = 0; i < TILE; i++) begin
                    r_acc[k][i] <= ((r_acc_j == '0) ? '0 : r_acc[k][i])
                                 + scale(rd_data[i*SW +: SW], wit_pkg::BT[k][r_acc_j]);
                end
            end
        end
    end

    // result rows straight from the accumulator buffer
    assign o_out.valid       = (r_state == ST_EMIT);
    assign o_out.out_value_0 = r_acc[r_out_row][0];
    assign o_out.out_value_1 = r_acc[r_out_row][1];
    assign o_out.out_value_2 = r_acc[r_out_row][2];
    assign o_out.out_value_3 = r_acc[r_out_row][3];
    assign o_out.out_value_4 = r_acc[r_out_row][4];
    assign o_out.out_value_5 = r_acc[r_out_row][5];
    assign o_out.out_row     = r_out_row;
    assign o_out.tile_done   = (r_out_row == LAST_ROW);

`ifndef SYNTHESIS
    // a tile is closed only while the result buffer is free
    a_close_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_rows == LAST_ROW)) |-> (r_state == ST_IDLE))
        else $error("tile closed while column pass busy");

    // stored rows come back in order, one per cycle
    a_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_vld && (r_acc_j != '0)) |->
            ($past(r_acc_vld) && (r_acc_j == $past(r_acc_j) + 1'b1)))
        else $error("stored rows read out of order");

    // after the last result row the buffer is released
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && (r_out_row == LAST_ROW)) |=> (r_state == ST_IDLE))
        else $error("buffer not released after last row");

    // row count never passes the tile edge
    a_rows_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= LAST_ROW)
        else $error("row count out of range");
`endif

endmodule
